// ===== rtl/ipsf_pkg.sv =====
// ----------------------------------------------------------------------------
// ipsf_pkg
// Types and constants shared by the IPv4 descending sort filter.
// ----------------------------------------------------------------------------
package ipsf_pkg;

	localparam logic [1:0] MODE_ALL    = 2'd0;
	localparam logic [1:0] MODE_FIRST  = 2'd1;
	localparam logic [1:0] MODE_FIRST2 = 2'd2;
	localparam logic [1:0] MODE_ANY    = 2'd3;

	localparam logic [1:0] REG_FILTER_MODE = 2'd0;
	localparam logic [1:0] REG_KEY_FIRST   = 2'd1;
	localparam logic [1:0] REG_KEY_SECOND  = 2'd2;

	typedef struct packed {
		logic [7:0] octet_a;
		logic [7:0] octet_b;
		logic [7:0] octet_c;
		logic [7:0] octet_d;
		logic       last_address;
	} item_t;

	typedef struct packed {
		logic [7:0] out_a;
		logic [7:0] out_b;
		logic [7:0] out_c;
		logic [7:0] out_d;
		logic       entry_valid;
		logic       last_result;
		logic       overflowed;
	} result_t;

	typedef struct packed {
		logic [1:0] filter_mode;
		logic [7:0] key_first;
		logic [7:0] key_second;
	} cfg_t;

	typedef struct packed {
		logic step;
		logic finish;
		logic overflow;
	} drain_ctrl_t;

endpackage

// ===== rtl/ipsf_cell.sv =====
// ----------------------------------------------------------------------------
// ipsf_cell
// One slot of the sorting chain: compare, hold or shift on insert, shift
// toward the head on drain.
// ----------------------------------------------------------------------------
module ipsf_cell (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ins,
	input  logic        drain,
	input  logic [31:0] addr,
	input  logic        prev_ge,
	input  logic [31:0] prev_data,
	input  logic        prev_valid,
	input  logic [31:0] next_data,
	input  logic        next_valid,
	output logic        ge,
	output logic [31:0] data,
	output logic        valid
);

	logic [31:0] data_q;
	logic        valid_q;

	assign ge    = valid_q && (data_q >= addr);
	assign data  = data_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (drain) begin
			valid_q <= next_valid;
		end else if (ins && !ge) begin
			valid_q <= prev_ge ? 1'b1 : prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			data_q <= next_data;
		end else if (ins && !ge) begin
			data_q <= prev_ge ? addr : prev_data;
		end
	end

endmodule

// ===== rtl/ipsf_emit.sv =====
// ----------------------------------------------------------------------------
// ipsf_emit
// Filter the head of the chain and issue results, holding one passing
// address back so the final one can be marked last.
// ----------------------------------------------------------------------------
module ipsf_emit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ipsf_pkg::drain_ctrl_t ctrl,
	input  ipsf_pkg::cfg_t        cfg,
	input  logic [31:0]           head,
	output logic                  res_valid,
	output ipsf_pkg::result_t     res
);

	logic [31:0]       pend_q;
	logic              pend_valid_q;
	logic              res_valid_q;
	ipsf_pkg::result_t res_q;
	logic              pass;

	always_comb begin
		case (cfg.filter_mode)
			ipsf_pkg::MODE_ALL:    pass = 1'b1;
			ipsf_pkg::MODE_FIRST:  pass = head[31:24] == cfg.key_first;
			ipsf_pkg::MODE_FIRST2: pass = (head[31:24] == cfg.key_first)
			                           && (head[23:16] == cfg.key_second);
			default:               pass = (head[31:24] == cfg.key_first)
			                           || (head[23:16] == cfg.key_first)
			                           || (head[15:8] == cfg.key_first)
			                           || (head[7:0] == cfg.key_first);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			res_valid_q <= (ctrl.step && pass && pend_valid_q) || ctrl.finish;
			if (ctrl.finish) begin
				pend_valid_q <= 1'b0;
			end else if (ctrl.step && pass) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step && pass) begin
			pend_q <= head;
		end
		if (ctrl.finish || (ctrl.step && pass)) begin
			res_q.out_a       <= pend_valid_q ? pend_q[31:24] : 8'd0;
			res_q.out_b       <= pend_valid_q ? pend_q[23:16] : 8'd0;
			res_q.out_c       <= pend_valid_q ? pend_q[15:8] : 8'd0;
			res_q.out_d       <= pend_valid_q ? pend_q[7:0] : 8'd0;
			res_q.entry_valid <= pend_valid_q;
			res_q.last_result <= ctrl.finish;
			res_q.overflowed  <= ctrl.overflow;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/ipv4_descending_sort_filter.sv =====
// ----------------------------------------------------------------------------
// ipv4_descending_sort_filter
// Insertion sorter for IPv4 addresses with a filtered descending drain.
// ----------------------------------------------------------------------------
// An address is taken whenever busy is low: unless the chain is full, a
// row of CAPACITY compare-and-shift cells places it in order in the same
// cycle. The item marked last raises busy until the chain has drained;
// the chain shifts one address per cycle past the filter at its head. Each
// result appears for one cycle with res_valid high and must be captured
// then; results may be spaced by filtered-out addresses. Configuration
// writes are ready only while busy is low.
module ipv4_descending_sort_filter #(
	parameter int CAPACITY = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ipsf_pkg::item_t   in,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	output logic              res_valid,
	output ipsf_pkg::result_t res
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t                state_q;
	ipsf_pkg::cfg_t        cfg_q;
	logic                  overflow_q;
	ipsf_pkg::drain_ctrl_t ctrl;

	logic        accept;
	logic        full;
	logic        ins;
	logic [31:0] addr;

	logic        cell_ge    [CAPACITY];
	logic [31:0] cell_data  [CAPACITY];
	logic        cell_valid [CAPACITY];

	assign addr      = {in.octet_a, in.octet_b, in.octet_c, in.octet_d};
	assign busy      = (state_q == ST_DRAIN);
	assign accept    = start && !busy;
	assign full      = cell_valid[CAPACITY-1];
	assign ins       = accept && !full;
	assign cfg_ready = !busy;

	assign ctrl.step     = (state_q == ST_DRAIN) && cell_valid[0];
	assign ctrl.finish   = (state_q == ST_DRAIN) && !cell_valid[0];
	assign ctrl.overflow = overflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ipsf_pkg::REG_FILTER_MODE: cfg_q.filter_mode <= cfg_data[1:0];
				ipsf_pkg::REG_KEY_FIRST:   cfg_q.key_first   <= cfg_data;
				ipsf_pkg::REG_KEY_SECOND:  cfg_q.key_second  <= cfg_data;
				default:                   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			overflow_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (full) begin
							overflow_q <= 1'b1;
						end
						if (in.last_address) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (!cell_valid[0]) begin
						overflow_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic        prev_ge;
		logic [31:0] prev_data;
		logic        prev_valid;
		logic [31:0] next_data;
		logic        next_valid;

		if (i == 0) begin : g_head
			assign prev_ge    = 1'b1;
			assign prev_data  = addr;
			assign prev_valid = 1'b1;
		end else begin : g_body
			assign prev_ge    = cell_ge[i-1];
			assign prev_data  = cell_data[i-1];
			assign prev_valid = cell_valid[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_data  = cell_data[i];
			assign next_valid = 1'b0;
		end else begin : g_inner
			assign next_data  = cell_data[i+1];
			assign next_valid = cell_valid[i+1];
		end

		ipsf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ins        (ins),
			.drain      (ctrl.step),
			.addr       (addr),
			.prev_ge    (prev_ge),
			.prev_data  (prev_data),
			.prev_valid (prev_valid),
			.next_data  (next_data),
			.next_valid (next_valid),
			.ge         (cell_ge[i]),
			.data       (cell_data[i]),
			.valid      (cell_valid[i])
		);
	end

	ipsf_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.cfg       (cfg_q),
		.head      (cell_data[0]),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule

// ===== tb/sv/ipv4_descending_sort_filter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_descending_sort_filter_test
// Self-checking bench for the IPv4 descending sort filter.
// ----------------------------------------------------------------------------
// Addresses go in as batches closed by a last item. A shadow sorter keeps
// the batch in descending order, applies the current filter on the last
// item and queues the results it predicts; each strobed result is checked
// field by field against the oldest one. Directed tests cover the register
// reset values, extreme addresses, every filter mode, the empty marker,
// register masking and the capacity limit; random batches follow.
// ----------------------------------------------------------------------------
module ipv4_descending_sort_filter_test;

	localparam int         CAPACITY      = 64;
	localparam int         SETTLE_CYCLES = 4;
	localparam int         STALL_LIMIT   = 2000;
	localparam int         RANDOM_ITEMS  = 50;
	localparam logic [1:0] REG_UNUSED    = 2'd3;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	ipsf_pkg::item_t   in_item;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [7:0]        cfg_data;
	logic              res_valid;
	ipsf_pkg::result_t res;

	logic [31:0]       sorted_addrs[$];
	ipsf_pkg::result_t expected_results[$];
	logic              batch_dropped;
	logic [1:0]        cur_mode;
	logic [7:0]        cur_key_first;
	logic [7:0]        cur_key_second;

	int errors;
	int results_seen;
	int items_sent;
	int burst_left;
	int stall_cycles;

	ipv4_descending_sort_filter #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.in       (in_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.res_valid(res_valid),
		.res      (res)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic bit address_selected(input logic [31:0] addr);
		case (cur_mode)
		ipsf_pkg::MODE_ALL: return 1'b1;
		ipsf_pkg::MODE_FIRST: return addr[31:24] == cur_key_first;
		ipsf_pkg::MODE_FIRST2:
			return addr[31:24] == cur_key_first && addr[23:16] == cur_key_second;
		default: return addr[31:24] == cur_key_first || addr[23:16] == cur_key_first ||
			addr[15:8] == cur_key_first || addr[7:0] == cur_key_first;
		endcase
	endfunction

	function automatic void absorb_address(input ipsf_pkg::item_t it);
		logic [31:0]       addr;
		ipsf_pkg::result_t r;
		int                pos;
		int                hits;
		addr = {it.octet_a, it.octet_b, it.octet_c, it.octet_d};
		if (sorted_addrs.size() >= CAPACITY) begin
			batch_dropped = 1'b1;
		end else begin
			pos = 0;
			while (pos < sorted_addrs.size() && sorted_addrs[pos] >= addr)
				pos++;
			sorted_addrs.insert(pos, addr);
		end
		if (!it.last_address)
			return;
		hits = 0;
		foreach (sorted_addrs[i]) begin
			if (address_selected(sorted_addrs[i])) begin
				r = '{sorted_addrs[i][31:24], sorted_addrs[i][23:16], sorted_addrs[i][15:8],
					sorted_addrs[i][7:0], 1'b1, 1'b0, batch_dropped};
				expected_results.insert(expected_results.size(), r);
				hits++;
			end
		end
		if (hits == 0) begin
			r = '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, batch_dropped};
		end else begin
			r = expected_results.pop_back();
			r.last_result = 1'b1;
		end
		expected_results.insert(expected_results.size(), r);
		sorted_addrs.delete();
		batch_dropped = 1'b0;
	endfunction

	function automatic logic [7:0] pick_octet();
		case ($urandom_range(0, 5))
		0: return cur_key_first;
		1: return cur_key_second;
		2: return 8'h00;
		3: return 8'hFF;
		default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_address(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
		input logic [7:0] d, input logic last_flag);
		ipsf_pkg::item_t it;
		it = '{a, b, c, d, last_flag};
		start   <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (busy);
		absorb_address(it);
		items_sent++;
	endtask

	task automatic hold_off(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// hold the sender until every predicted result has been seen
	task automatic settle_idle();
		start <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic pace();
		if (burst_left == 0) begin
			hold_off($urandom_range(1, 6));
			burst_left = $urandom_range(0, 15);
		end else begin
			burst_left--;
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		ipsf_pkg::REG_FILTER_MODE: cur_mode = val[1:0];
		ipsf_pkg::REG_KEY_FIRST: cur_key_first = val;
		ipsf_pkg::REG_KEY_SECOND: cur_key_second = val;
		default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic report_mismatch(input string field, input logic [7:0] want,
		input logic [7:0] got);
		errors++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endtask

	always @(posedge clk) begin : check_results
		ipsf_pkg::result_t want;
		if (arst_n && res_valid) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %p", $time, res);
			end else begin
				want = expected_results.pop_front();
				if (res.out_a !== want.out_a)
					report_mismatch("out_a", want.out_a, res.out_a);
				if (res.out_b !== want.out_b)
					report_mismatch("out_b", want.out_b, res.out_b);
				if (res.out_c !== want.out_c)
					report_mismatch("out_c", want.out_c, res.out_c);
				if (res.out_d !== want.out_d)
					report_mismatch("out_d", want.out_d, res.out_d);
				if (res.entry_valid !== want.entry_valid)
					report_mismatch("entry_valid", 8'(want.entry_valid),
						8'(res.entry_valid));
				if (res.last_result !== want.last_result)
					report_mismatch("last_result", 8'(want.last_result),
						8'(res.last_result));
				if (res.overflowed !== want.overflowed)
					report_mismatch("overflowed", 8'(want.overflowed), 8'(res.overflowed));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || res_valid || (cfg_valid && cfg_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic test_reset_defaults();
		send_address(8'd10, 8'd0, 8'd0, 8'd1, 1'b0);
		send_address(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
		send_address(8'd10, 8'd0, 8'd0, 8'd1, 1'b0);
		send_address(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		settle_idle();
	endtask

	task automatic test_single_item();
		send_address(8'd192, 8'd168, 8'd1, 8'd1, 1'b1);
		send_address(8'd170, 8'd85, 8'd170, 8'd85, 1'b1);
		settle_idle();
	endtask

	task automatic test_filter_modes();
		write_reg(ipsf_pkg::REG_FILTER_MODE, 8'(ipsf_pkg::MODE_FIRST));
		write_reg(ipsf_pkg::REG_KEY_FIRST, 8'd192);
		send_address(8'd192, 8'd168, 8'd0, 8'd1, 1'b0);
		send_address(8'd10, 8'd192, 8'd0, 8'd0, 1'b0);
		send_address(8'd192, 8'd0, 8'd0, 8'd0, 1'b0);
		send_address(8'd193, 8'd168, 8'd0, 8'd1, 1'b1);
		settle_idle();
		write_reg(ipsf_pkg::REG_FILTER_MODE, 8'(ipsf_pkg::MODE_FIRST2));
		write_reg(ipsf_pkg::REG_KEY_SECOND, 8'd168);
		send_address(8'd192, 8'd168, 8'd5, 8'd5, 1'b0);
		send_address(8'd192, 8'd169, 8'd1, 8'd1, 1'b0);
		send_address(8'd192, 8'd168, 8'd0, 8'd0, 1'b1);
		settle_idle();
		write_reg(ipsf_pkg::REG_KEY_FIRST, 8'd0);
		write_reg(ipsf_pkg::REG_KEY_SECOND, 8'd0);
		send_address(8'd0, 8'd0, 8'd1, 8'd2, 1'b1);
		settle_idle();
		write_reg(ipsf_pkg::REG_FILTER_MODE, 8'(ipsf_pkg::MODE_ANY));
		write_reg(ipsf_pkg::REG_KEY_FIRST, 8'd255);
		send_address(8'd1, 8'd2, 8'd3, 8'd255, 1'b0);
		send_address(8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
		send_address(8'd7, 8'd7, 8'd7, 8'd7, 1'b0);
		send_address(8'd0, 8'd255, 8'd0, 8'd0, 1'b1);
		settle_idle();
		// nothing passes: empty marker
		write_reg(ipsf_pkg::REG_FILTER_MODE, 8'(ipsf_pkg::MODE_FIRST));
		write_reg(ipsf_pkg::REG_KEY_FIRST, 8'd0);
		send_address(8'd1, 8'd0, 8'd0, 8'd0, 1'b1);
		settle_idle();
	endtask

	task automatic test_register_writes();
		write_reg(ipsf_pkg::REG_FILTER_MODE, 8'hFD);
		write_reg(ipsf_pkg::REG_KEY_FIRST, 8'hAA);
		write_reg(REG_UNUSED, 8'h55);
		send_address(8'd170, 8'd1, 8'd1, 8'd1, 1'b0);
		send_address(8'd85, 8'd85, 8'd85, 8'd85, 1'b1);
		settle_idle();
		write_reg(ipsf_pkg::REG_FILTER_MODE, 8'(ipsf_pkg::MODE_ALL));
	endtask

	task automatic test_capacity();
		for (int i = 0; i < CAPACITY; i++) begin
			send_address(pick_octet(), pick_octet(), pick_octet(), pick_octet(),
				i == CAPACITY - 1);
			pace();
		end
		settle_idle();
		// full store drops the tail of the batch, last item included
		for (int i = 0; i <= CAPACITY + 1; i++) begin
			send_address(pick_octet(), pick_octet(), pick_octet(), pick_octet(),
				i == CAPACITY + 1);
			pace();
		end
		settle_idle();
	endtask

	task automatic test_random_batches();
		int          stop_at;
		int          count;
		logic [31:0] addr;
		stop_at = items_sent + RANDOM_ITEMS;
		addr    = '0;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 1)) begin
				settle_idle();
				if ($urandom_range(0, 1))
					write_reg(ipsf_pkg::REG_FILTER_MODE, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 1))
					write_reg(ipsf_pkg::REG_KEY_FIRST, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 1))
					write_reg(ipsf_pkg::REG_KEY_SECOND, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 7) == 0)
					write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
			end
			count = $urandom_range(1, 10);
			for (int i = 0; i < count; i++) begin
				if ($urandom_range(0, 7) != 0)
					addr = {pick_octet(), pick_octet(), pick_octet(), pick_octet()};
				send_address(addr[31:24], addr[23:16], addr[15:8], addr[7:0], i == count - 1);
				pace();
			end
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		start          <= 1'b0;
		in_item        <= '0;
		cfg_valid      <= 1'b0;
		cfg_index      <= ipsf_pkg::REG_FILTER_MODE;
		cfg_data       <= '0;
		cur_mode       = ipsf_pkg::MODE_ALL;
		cur_key_first  = '0;
		cur_key_second = '0;
		batch_dropped  = 1'b0;
		errors         = 0;
		results_seen   = 0;
		items_sent     = 0;
		burst_left     = 0;
		stall_cycles   = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_single_item();
		test_filter_modes();
		test_register_writes();
		test_capacity();
		test_random_batches();

		settle_idle();
		repeat (16) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ipsf_pkg.sv
rtl/ipsf_cell.sv
rtl/ipsf_emit.sv
rtl/ipv4_descending_sort_filter.sv
tb/sv/ipv4_descending_sort_filter_test.sv
